[design/assert_macros.svh]
// Assertion macros shared by the hexagonal cell finder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent a fixed number of cycles later
`define HC_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);
`else
`define HC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define HC_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg)
`endif
`endif

[design/hcfp_pkg.sv]
// Package: widths, register codes and fixed-point constants of the hex cell finder
package hcfp_pkg;

  // default fraction bits of positions and offsets
  localparam int FRAC_BITS_DEF = 16;

  // port widths
  localparam int POS_W     = 32;
  localparam int LAYER_W   = 16;
  localparam int CELL_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SIDE_W    = 31;
  localparam int INV_W     = 32;

  // stagger modes
  typedef enum logic [1:0] {
    STAG_SIDE    = 2'd0,
    STAG_MOD3    = 2'd1,
    STAG_QUARTER = 2'd2,
    STAG_NONE    = 2'd3
  } stagger_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAGGER = 3'd0,
    CFG_SIDE    = 3'd1,
    CFG_INV     = 3'd2,
    CFG_OFS_X   = 3'd3,
    CFG_OFS_Y   = 3'd4
  } cfg_idx_t;

  // direction of the quarter-hex Y step
  typedef enum logic [1:0] {
    YD_NONE = 2'd0,
    YD_SUB  = 2'd1,
    YD_ADD  = 2'd2
  } ydir_t;

  // register reset values
  localparam logic [SIDE_W-1:0] SIDE_RST = 31'd65536;
  localparam logic [INV_W-1:0]  INV_RST  = 32'd16777216;

  // reciprocal has 24 fraction bits
  localparam int INV_FRAC = 24;

  // 1/sqrt(3) in Q.30, split into two 15-bit halves
  localparam logic [29:0] ISQ3      = 30'd619925131;
  localparam int          ISQ3_FRAC = 30;
  localparam int          ISQ3_CUT  = 15;
  localparam logic [14:0] ISQ3_HI   = ISQ3[29:15];
  localparam logic [14:0] ISQ3_LO   = ISQ3[14:0];

  // sqrt(3)/4 in Q.30
  localparam logic [28:0] SQ3_4      = 29'd464943848;
  localparam int          SQ3_4_FRAC = 30;

  // saturation limits of the cell indices
  localparam int CELL_MAX = 32767;
  localparam int CELL_MIN = -32768;

endpackage

[design/hex_cell_from_position.sv]
// Top level: hexagonal cell finder, hit position to cell column and row
// Pipeline: each accepted start passes through the register stages below, and result and
// done leave the last stage together; one item per cycle.
// The depth comes from the reciprocal multiply (split in halves, then summed), the
// 1/sqrt(3) multiply and the divide-by-three step, each with its own register stage.
// busy is high only during reset; the receiver cannot stall, so no item is ever held.
// Synchronous reset clears the valid pipeline and loads the register reset values.
`include "assert_macros.svh"

module hex_cell_from_position #(
  parameter int FRAC_BITS = hcfp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic signed [hcfp_pkg::POS_W-1:0]   pos_x,
  input  logic signed [hcfp_pkg::POS_W-1:0]   pos_y,
  input  logic        [hcfp_pkg::LAYER_W-1:0] layer,
  output logic signed [hcfp_pkg::CELL_W-1:0]  cell_x,
  output logic signed [hcfp_pkg::CELL_W-1:0]  cell_y,
  input  logic                                cfg_we,
  input  logic [hcfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hcfp_pkg::CFG_W-1:0]          cfg_data
);

  localparam int F      = FRAC_BITS;
  localparam int NSTAGE = 8;
  localparam int PW0    = hcfp_pkg::POS_W + 1;      // offset-removed position
  localparam int XW     = hcfp_pkg::POS_W + 2;      // after stagger shift
  localparam int MW     = XW + 17;                  // x times half reciprocal
  localparam int FW     = MW + 16;                  // full reciprocal product
  localparam int UW     = 42;                       // side units
  localparam int VMW    = UW + 16;                  // v times half of 1/sqrt3
  localparam int VFW    = VMW + hcfp_pkg::ISQ3_CUT; // full 1/sqrt3 product
  localparam int WW     = 42;
  localparam int PW     = UW - F;                   // floor(u / 2^F)
  localparam int IXW    = PW + 2;
  localparam int IY0W   = WW - F + 1;
  localparam int IYW    = IY0W + 1;
  localparam int QW     = 30;                       // quarter-hex step

  // divide-by-three reciprocal for values below 2^(PW-1)
  localparam logic [63:0]   DIV3_FULL = ((64'd1 << PW) + 64'd2) / 64'd3;
  localparam logic [PW-2:0] DIV3_M    = DIV3_FULL[PW-2:0];

  localparam logic [F:0]   ONE_D = {1'b1, {F{1'b0}}};
  localparam logic [F+2:0] ONE_E = {3'b001, {F{1'b0}}};
  localparam logic [F+2:0] DEN   = {3'b011, {F{1'b0}}};
  localparam logic [F+2:0] DEN2  = {3'b110, {F{1'b0}}};

  localparam logic signed [IXW-1:0] IX_MAX = IXW'(hcfp_pkg::CELL_MAX);
  localparam logic signed [IXW-1:0] IX_MIN = IXW'(hcfp_pkg::CELL_MIN);
  localparam logic signed [IYW-1:0] IY_MAX = IYW'(hcfp_pkg::CELL_MAX);
  localparam logic signed [IYW-1:0] IY_MIN = IYW'(hcfp_pkg::CELL_MIN);

  // layer mod 3: base-4 digit sum, folded once more
  function automatic logic [1:0] mod3_u16(input logic [hcfp_pkg::LAYER_W-1:0] val);
    logic [4:0] dsum;
    logic [2:0] fold;
    logic [1:0] res;
    dsum = '0;
    for (int i = 0; i < hcfp_pkg::LAYER_W / 2; i++) begin
      dsum = dsum + 5'(val[2*i +: 2]);
    end
    fold = 3'(dsum[1:0]) + 3'(dsum[3:2]) + 3'(dsum[4]);
    case (fold)
      3'd0, 3'd3, 3'd6: res = 2'd0;
      3'd1, 3'd4, 3'd7: res = 2'd1;
      default:          res = 2'd2;
    endcase
    return res;
  endfunction

  // configuration registers
  hcfp_pkg::stagger_t                    stagger_mode;
  logic [hcfp_pkg::SIDE_W-1:0]           hex_side;
  logic [hcfp_pkg::INV_W-1:0]            inv_side_length;
  logic signed [hcfp_pkg::POS_W-1:0]     org_x;
  logic signed [hcfp_pkg::POS_W-1:0]     org_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      stagger_mode    <= hcfp_pkg::STAG_MOD3;
      hex_side        <= hcfp_pkg::SIDE_RST;
      inv_side_length <= hcfp_pkg::INV_RST;
      org_x           <= '0;
      org_y           <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hcfp_pkg::CFG_STAGGER: stagger_mode    <= hcfp_pkg::stagger_t'(cfg_data[1:0]);
        hcfp_pkg::CFG_SIDE:    hex_side        <= cfg_data[hcfp_pkg::SIDE_W-1:0];
        hcfp_pkg::CFG_INV:     inv_side_length <= cfg_data;
        hcfp_pkg::CFG_OFS_X:   org_x           <= $signed(cfg_data);
        hcfp_pkg::CFG_OFS_Y:   org_y           <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // handshake and valid pipeline
  logic              accept;
  logic [NSTAGE-1:0] vld;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-2:0], accept};
    end
  end

  // stage 1: offsets, stagger amount, quarter-hex step
  logic [1:0]              lmod3;
  logic [XW-1:0]           side34;
  logic [32:0]             side_x3;
  logic [30:0]             side_q34;
  logic [59:0]             q_prod;
  logic signed [XW-1:0]    xadd_next;
  hcfp_pkg::ydir_t         ydir_next;

  assign lmod3    = mod3_u16(layer);
  assign side34   = {3'b000, hex_side};
  assign side_x3  = {2'b00, hex_side} + {1'b0, hex_side, 1'b0};
  assign side_q34 = side_x3[32:2];
  assign q_prod   = hex_side * hcfp_pkg::SQ3_4;

  always_comb begin
    xadd_next = '0;
    ydir_next = hcfp_pkg::YD_NONE;
    case (stagger_mode)
      hcfp_pkg::STAG_SIDE: xadd_next = -$signed(side34);
      hcfp_pkg::STAG_MOD3: begin
        case (lmod3)
          2'd1:    xadd_next = -$signed(side34);
          2'd2:    xadd_next = -$signed({side34[XW-2:0], 1'b0});
          default: xadd_next = '0;
        endcase
      end
      hcfp_pkg::STAG_QUARTER: begin
        case (layer[1:0])
          2'd0:    xadd_next = $signed({3'b000, side_q34});
          2'd1:    ydir_next = hcfp_pkg::YD_SUB;
          2'd2:    ydir_next = hcfp_pkg::YD_ADD;
          default: xadd_next = -$signed({3'b000, side_q34});
        endcase
      end
      default: ;
    endcase
  end

  logic signed [PW0-1:0] s1_dx;
  logic signed [PW0-1:0] s1_dy;
  logic signed [XW-1:0]  s1_xadd;
  hcfp_pkg::ydir_t       s1_ydir;
  logic [QW-1:0]         s1_q;

  always_ff @(posedge clk) begin
    s1_dx   <= {pos_x[hcfp_pkg::POS_W-1], pos_x} - {org_x[hcfp_pkg::POS_W-1], org_x};
    s1_dy   <= {pos_y[hcfp_pkg::POS_W-1], pos_y} - {org_y[hcfp_pkg::POS_W-1], org_y};
    s1_xadd <= xadd_next;
    s1_ydir <= ydir_next;
    s1_q    <= q_prod[hcfp_pkg::SQ3_4_FRAC +: QW];
  end

  // stage 2: apply stagger shift
  logic signed [XW-1:0] dy_ext;
  logic signed [XW-1:0] y2_next;
  logic signed [XW-1:0] s2_x;
  logic signed [XW-1:0] s2_y;

  assign dy_ext = {s1_dy[PW0-1], s1_dy};

  always_comb begin
    case (s1_ydir)
      hcfp_pkg::YD_SUB: y2_next = dy_ext - $signed({4'b0000, s1_q});
      hcfp_pkg::YD_ADD: y2_next = dy_ext + $signed({4'b0000, s1_q});
      default:          y2_next = dy_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    s2_x <= {s1_dx[PW0-1], s1_dx} + s1_xadd;
    s2_y <= y2_next;
  end

  // stage 3: position times reciprocal halves
  logic signed [MW-1:0] s3_xh;
  logic signed [MW-1:0] s3_xl;
  logic signed [MW-1:0] s3_yh;
  logic signed [MW-1:0] s3_yl;

  always_ff @(posedge clk) begin
    s3_xh <= s2_x * $signed({1'b0, inv_side_length[31:16]});
    s3_xl <= s2_x * $signed({1'b0, inv_side_length[15:0]});
    s3_yh <= s2_y * $signed({1'b0, inv_side_length[31:16]});
    s3_yl <= s2_y * $signed({1'b0, inv_side_length[15:0]});
  end

  // stage 4: recombine and floor to side units
  logic signed [FW-1:0] xfull;
  logic signed [FW-1:0] yfull;
  logic signed [UW-1:0] s4_u;
  logic signed [UW-1:0] s4_v;

  assign xfull = $signed({s3_xh, 16'h0000}) + $signed({{16{s3_xl[MW-1]}}, s3_xl});
  assign yfull = $signed({s3_yh, 16'h0000}) + $signed({{16{s3_yl[MW-1]}}, s3_yl});

  always_ff @(posedge clk) begin
    s4_u <= xfull[hcfp_pkg::INV_FRAC +: UW];
    s4_v <= yfull[hcfp_pkg::INV_FRAC +: UW];
  end

  // stage 5: v times 1/sqrt3 halves; fold u into a magnitude for the divide
  logic signed [PW-1:0]  p_div;
  logic signed [VMW-1:0] s5_vh;
  logic signed [VMW-1:0] s5_vl;
  logic [PW-2:0]         s5_n;
  logic                  s5_neg;
  logic [F-1:0]          s5_ulow;

  assign p_div = s4_u[UW-1:F];

  always_ff @(posedge clk) begin
    s5_vh   <= s4_v * $signed({1'b0, hcfp_pkg::ISQ3_HI});
    s5_vl   <= s4_v * $signed({1'b0, hcfp_pkg::ISQ3_LO});
    s5_neg  <= p_div[PW-1];
    s5_n    <= p_div[PW-1] ? ~p_div[PW-2:0] : p_div[PW-2:0];
    s5_ulow <= s4_u[F-1:0];
  end

  // stage 6: w, and quotient by three through the reciprocal
  logic signed [VFW-1:0] vfull;
  logic [2*PW-3:0]       div3_prod;
  logic signed [WW-1:0]  s6_w;
  logic [PW-3:0]         s6_a;
  logic [PW-2:0]         s6_n;
  logic                  s6_neg;
  logic [F-1:0]          s6_ulow;

  assign vfull = $signed({s5_vh, {hcfp_pkg::ISQ3_CUT{1'b0}}})
               + $signed({{hcfp_pkg::ISQ3_CUT{s5_vl[VMW-1]}}, s5_vl});
  assign div3_prod = s5_n * DIV3_M;

  always_ff @(posedge clk) begin
    s6_w    <= vfull[hcfp_pkg::ISQ3_FRAC +: WW];
    s6_a    <= div3_prod[2*PW-3:PW];
    s6_n    <= s5_n;
    s6_neg  <= s5_neg;
    s6_ulow <= s5_ulow;
  end

  // stage 7: remainder, base column, fraction distances, raw row
  logic [PW-2:0]        a3;
  logic [PW-2:0]        b3_diff;
  logic [1:0]           b3;
  logic [1:0]           r3;
  logic [PW-1:0]        a_ext;
  logic [PW-1:0]        q1;
  logic                 half_up;
  logic [F-1:0]         ra;
  logic [F:0]           d_next;
  logic signed [PW:0]   s7_ix0;
  logic [F+2:0]         s7_e;
  logic [F:0]           s7_d;
  logic signed [IY0W-1:0] s7_iy0;

  assign a3      = {1'b0, s6_a} + {s6_a, 1'b0};
  assign b3_diff = s6_n - a3;
  assign b3      = b3_diff[1:0];
  assign r3      = s6_neg ? (2'd2 - b3) : b3;
  assign a_ext   = {2'b00, s6_a};
  assign q1      = s6_neg ? ~a_ext : a_ext;
  assign half_up = (r3 == 2'd2) || ((r3 == 2'd1) && s6_ulow[F-1]);
  assign ra      = s6_w[F-1:0];

  // d = |2*ra - 2^F|
  always_comb begin
    if (ra[F-1]) begin
      d_next = {1'b0, ra[F-2:0], 1'b0};
    end else begin
      d_next = ONE_D - {1'b0, ra[F-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    s7_ix0 <= $signed({q1, half_up});
    s7_e   <= {r3, s6_ulow, 1'b0};
    s7_d   <= d_next;
    s7_iy0 <= s6_w[WW-1:F-1];
  end

  // stage 8: column corrections, row parity, saturation
  logic                   col_lo;
  logic                   col_hi;
  logic signed [IXW-1:0]  ix;
  logic signed [IYW-1:0]  iy;
  logic                   par;

  assign col_lo = (s7_e < DEN) && ((DEN - s7_e) < {2'b00, s7_d});
  assign col_hi = (s7_e > DEN) && ((DEN2 - s7_e) < (ONE_E - {2'b00, s7_d}));
  assign ix     = $signed(IXW'(s7_ix0)) + $signed({{(IXW-1){1'b0}}, col_lo | col_hi});
  assign par    = ix[0] ^ s7_iy0[0];
  assign iy     = $signed(IYW'(s7_iy0)) - $signed({{(IYW-1){1'b0}}, par});

  always_ff @(posedge clk) begin
    if (ix > IX_MAX) begin
      cell_x <= 16'sh7fff;
    end else if (ix < IX_MIN) begin
      cell_x <= 16'sh8000;
    end else begin
      cell_x <= ix[hcfp_pkg::CELL_W-1:0];
    end
    if (iy > IY_MAX) begin
      cell_y <= 16'sh7fff;
    end else if (iy < IY_MIN) begin
      cell_y <= 16'sh8000;
    end else begin
      cell_y <= iy[hcfp_pkg::CELL_W-1:0];
    end
  end

  // checks
  `HC_ASSERT_DELAY(a_latency, clk, rst, accept, 8, done, "accepted item gave no result")
  `HC_ASSERT_IMPL(a_no_phantom, clk, rst, done, $past(accept, NSTAGE), "result without item")
  `HC_ASSERT_IMPL(a_div3_rem, clk, rst, vld[5], b3 <= 2'd2, "divide by three remainder out of range")
  `HC_ASSERT_IMPL(a_row_parity, clk, rst, vld[NSTAGE-2], ix[0] == iy[0], "row parity not aligned")

endmodule

[dv/tb_hex_cell_from_position.sv]
// Testbench for the hex cell finder: directed table and random items checked against a predictor
module tb_hex_cell_from_position;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC          = hcfp_pkg::FRAC_BITS_DEF;
  localparam longint UNIT          = 64'sd1 <<< FRAC;
  localparam longint COL_PITCH     = 3 * UNIT;
  localparam int     HALF_PITCH    = 3 << (FRAC - 1);
  // 1/sqrt(3) and sqrt(3)/4, both Q.30
  localparam longint INV_ROOT3_Q30 = 64'sd619925131;
  localparam longint ROOT3_QTR_Q30 = 64'sd464943848;
  localparam int     LATENCY       = 8;

  typedef struct packed {
    logic signed [hcfp_pkg::CELL_W-1:0] col;
    logic signed [hcfp_pkg::CELL_W-1:0] row;
  } cell_t;

  // one row of the directed table; want is only used where typed is set
  typedef struct packed {
    logic [hcfp_pkg::POS_W-1:0]   px;
    logic [hcfp_pkg::POS_W-1:0]   py;
    logic [hcfp_pkg::LAYER_W-1:0] lay;
    logic                         typed;
    cell_t                        want;
  } probe_t;

  typedef struct {
    hcfp_pkg::stagger_t                 mode;
    logic [hcfp_pkg::SIDE_W-1:0]        side;
    logic [hcfp_pkg::INV_W-1:0]         inv;
    logic signed [hcfp_pkg::POS_W-1:0]  ofs_x;
    logic signed [hcfp_pkg::POS_W-1:0]  ofs_y;
  } grid_cfg_t;

  localparam int N_PROBES = 20;
  localparam probe_t PROBES [N_PROBES] = '{
    // after reset: origin, and the Y extremes that clamp the row
    '{32'h00000000, 32'h00000000, 16'h0000, 1'b1, '{16'sd0, 16'sd0}},
    '{32'h00000000, 32'h7FFFFFFF, 16'h0000, 1'b1, '{16'sd0, 16'sh7FFF}},
    '{32'h00000000, 32'h80000000, 16'h0000, 1'b1, '{16'sd0, 16'sh8000}},
    // X extremes and both corners
    '{32'h7FFFFFFF, 32'h00000000, 16'h0000, 1'b0, '0},
    '{32'h80000000, 32'h00000000, 16'h0000, 1'b0, '0},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0, '0},
    '{32'h80000000, 32'h80000000, 16'hFFFF, 1'b0, '0},
    // column fraction exactly a half, either sign
    '{32'h00018000, 32'h00000000, 16'h0000, 1'b0, '0},
    '{32'hFFFE8000, 32'h00000000, 16'h0000, 1'b0, '0},
    '{32'h00018000, 32'h00008000, 16'h0000, 1'b0, '0},
    // layer selects the shift
    '{32'h00000000, 32'h00000000, 16'h0001, 1'b0, '0},
    '{32'h00000000, 32'h00000000, 16'h0002, 1'b0, '0},
    '{32'h00000000, 32'h00000000, 16'h0003, 1'b0, '0},
    '{32'h00010000, 32'h00010000, 16'h0004, 1'b0, '0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0005, 1'b0, '0},
    '{32'h00000001, 32'h00000001, 16'h0000, 1'b0, '0},
    '{32'h55555555, 32'hAAAAAAAA, 16'h5555, 1'b0, '0},
    '{32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 1'b0, '0},
    '{32'h00030000, 32'h0001BB68, 16'h0002, 1'b0, '0},
    '{32'hFFFD0000, 32'hFFFE4498, 16'h0007, 1'b0, '0}
  };

  localparam int N_PHASES   = 16;
  localparam int PHASE_ITEMS = 96;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                start     = 1'b0;
  logic                                busy;
  logic                                done;
  logic signed [hcfp_pkg::POS_W-1:0]   pos_x     = '0;
  logic signed [hcfp_pkg::POS_W-1:0]   pos_y     = '0;
  logic [hcfp_pkg::LAYER_W-1:0]        layer     = '0;
  logic signed [hcfp_pkg::CELL_W-1:0]  cell_x;
  logic signed [hcfp_pkg::CELL_W-1:0]  cell_y;
  logic                                cfg_we    = 1'b0;
  logic [hcfp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [hcfp_pkg::CFG_W-1:0]          cfg_data  = '0;

  grid_cfg_t grid = '{hcfp_pkg::STAG_MOD3, 31'd65536, 32'd16777216, 32'sd0, 32'sd0};
  cell_t     cells_due [$];
  int        mismatches = 0;
  int        results_seen = 0;

  hex_cell_from_position DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .layer     (layer),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // floor(val * k / 2^sh), exact
  function automatic longint scale_floor(longint val, longint k, int sh);
    logic signed [127:0] a;
    logic signed [127:0] b;
    logic signed [127:0] p;
    a = val;
    b = k;
    p = (a * b) >>> sh;
    return p[63:0];
  endfunction

  // floor division, positive divisor
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic logic signed [hcfp_pkg::CELL_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[hcfp_pkg::CELL_W-1:0];
  endfunction

  // expected column and row of the cell holding one hit
  function automatic cell_t locate_cell(logic signed [hcfp_pkg::POS_W-1:0] px,
                                        logic signed [hcfp_pkg::POS_W-1:0] py,
                                        logic [hcfp_pkg::LAYER_W-1:0] lay);
    longint side, x, y, q, u, v, w, rb, ra, d, ix, iy;
    cell_t  c;
    side = longint'(grid.side);
    x = longint'(px) - longint'(grid.ofs_x);
    y = longint'(py) - longint'(grid.ofs_y);
    // stagger shift
    case (grid.mode)
      hcfp_pkg::STAG_SIDE: x -= side;
      hcfp_pkg::STAG_MOD3: x -= longint'(lay % 16'd3) * side;
      hcfp_pkg::STAG_QUARTER: begin
        q = (side * ROOT3_QTR_Q30) >>> 30;
        case (lay[1:0])
          2'd0: x += (3 * side) >>> 2;
          2'd1: y -= q;
          2'd2: y += q;
          default: x -= (3 * side) >>> 2;
        endcase
      end
      default: ;
    endcase
    // to side units, then the row axis
    u = scale_floor(x, longint'(grid.inv), hcfp_pkg::INV_FRAC);
    v = scale_floor(y, longint'(grid.inv), hcfp_pkg::INV_FRAC);
    w = scale_floor(v, INV_ROOT3_Q30, 30);
    rb = u - floor_div(u, COL_PITCH) * COL_PITCH;
    ra = w & (UNIT - 1);
    d = 2 * ra - UNIT;
    if (d < 0) d = -d;
    // column with edge corrections; an exact half gets none
    ix = floor_div(2 * u, COL_PITCH);
    if (2 * rb < COL_PITCH && -d < 2 * rb - COL_PITCH) ix += 1;
    if (2 * rb > COL_PITCH && d - UNIT < 2 * (rb - COL_PITCH)) ix += 1;
    // row, parity aligned with the column before clamping
    iy = w >>> (FRAC - 1);
    iy -= (ix + iy) & 64'sd1;
    c.col = clamp16(ix);
    c.row = clamp16(iy);
    return c;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    cell_t due;
    if (!rst && done) begin
      if (cells_due.size() == 0) begin
        flag_mismatch("unexpected result, cell_x", cell_x, 0);
      end else begin
        due = cells_due.pop_front();
        if (cell_x !== due.col) flag_mismatch("cell_x", cell_x, due.col);
        if (cell_y !== due.row) flag_mismatch("cell_y", cell_y, due.row);
      end
      results_seen++;
    end
  end

  // register write, called at a falling edge; leaves cfg_we high
  task automatic write_reg(logic [hcfp_pkg::CFG_IDX_W-1:0] idx,
                           logic [hcfp_pkg::CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    case (idx)
      hcfp_pkg::CFG_STAGGER: grid.mode = hcfp_pkg::stagger_t'(data[1:0]);
      hcfp_pkg::CFG_SIDE:    grid.side = data[hcfp_pkg::SIDE_W-1:0];
      hcfp_pkg::CFG_INV:     grid.inv = data;
      hcfp_pkg::CFG_OFS_X:   grid.ofs_x = data;
      hcfp_pkg::CFG_OFS_Y:   grid.ofs_y = data;
      default: ;
    endcase
  endtask

  // full register set, unused bits random, plus one write to an unused index
  task automatic set_grid(hcfp_pkg::stagger_t m, logic [hcfp_pkg::SIDE_W-1:0] side_v,
                          logic [hcfp_pkg::INV_W-1:0] inv_v,
                          logic [hcfp_pkg::POS_W-1:0] ox, logic [hcfp_pkg::POS_W-1:0] oy);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(hcfp_pkg::CFG_STAGGER, {junk[31:2], m});
    write_reg(hcfp_pkg::CFG_SIDE, {junk[0], side_v});
    write_reg(hcfp_pkg::CFG_INV, inv_v);
    write_reg(hcfp_pkg::CFG_OFS_X, ox);
    write_reg(hcfp_pkg::CFG_OFS_Y, oy);
    write_reg(hcfp_pkg::CFG_IDX_W'($urandom_range(5, 7)), $urandom());
    cfg_we = 1'b0;
  endtask

  function automatic logic [hcfp_pkg::SIDE_W-1:0] pick_side();
    return hcfp_pkg::SIDE_W'($urandom_range(32'h1000, 32'h100000));
  endfunction

  // Q8.24 reciprocal of a Q16.16 side, rounded
  function automatic logic [hcfp_pkg::INV_W-1:0] recip_of(logic [hcfp_pkg::SIDE_W-1:0] side_v);
    longint s;
    s = longint'(side_v);
    return hcfp_pkg::INV_W'(((64'sd1 <<< 40) + s / 2) / s);
  endfunction

  function automatic logic [hcfp_pkg::POS_W-1:0] small_ofs();
    return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
  endfunction

  function automatic logic [hcfp_pkg::POS_W-1:0] pick_pos();
    int r, k, j;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
    if (r < 70) begin
      // around column half-pitch boundaries
      k = $urandom_range(0, 400);
      j = $urandom_range(0, 2);
      return hcfp_pkg::POS_W'((k - 200) * HALF_PITCH + j - 1);
    end
    if (r < 90) return $urandom();
    case ($urandom_range(0, 6))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hFFFFFFFF;
      4: return 32'h00000001;
      5: return 32'h7FFF0000;
      default: return 32'h80010000;
    endcase
  endfunction

  function automatic logic [hcfp_pkg::LAYER_W-1:0] pick_layer();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return hcfp_pkg::LAYER_W'($urandom_range(0, 15));
    if (r < 9) return hcfp_pkg::LAYER_W'($urandom());
    return ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one item from a falling edge until it is taken
  task automatic send_item(logic [hcfp_pkg::POS_W-1:0] px, logic [hcfp_pkg::POS_W-1:0] py,
                           logic [hcfp_pkg::LAYER_W-1:0] lay, logic typed, cell_t want);
    start = 1'b1;
    pos_x = px;
    pos_y = py;
    layer = lay;
    do @(posedge clk); while (busy);
    if (typed) cells_due.push_back(want);
    else cells_due.push_back(locate_cell(px, py, lay));
    @(negedge clk);
  endtask

  task automatic idle(int n);
    if (n == 0) return;
    start = 1'b0;
    pos_x = $urandom();
    pos_y = $urandom();
    layer = hcfp_pkg::LAYER_W'($urandom());
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (cells_due.size() != 0) @(negedge clk);
  endtask

  task automatic configure_phase(int k);
    logic [hcfp_pkg::SIDE_W-1:0] s;
    logic [hcfp_pkg::INV_W-1:0]  inv_v;
    hcfp_pkg::stagger_t          m;
    s = pick_side();
    case (k)
      0: ;  // keep the reset values
      1: set_grid(hcfp_pkg::STAG_SIDE, 31'd65536, 32'd16777216, '0, '0);
      2: set_grid(hcfp_pkg::STAG_QUARTER, s, recip_of(s), small_ofs(), small_ofs());
      3: set_grid(hcfp_pkg::STAG_NONE, s, recip_of(s), small_ofs(), small_ofs());
      4: set_grid(hcfp_pkg::STAG_MOD3, 31'h7FFFFFFF, 32'd1, '0, '0);
      5: set_grid(hcfp_pkg::STAG_QUARTER, 31'h7FFFFFFF, 32'hFFFFFFFF, small_ofs(), small_ofs());
      // zero side and reciprocal
      6: set_grid(hcfp_pkg::STAG_SIDE, 31'd0, 32'd0, small_ofs(), small_ofs());
      7: set_grid(hcfp_pkg::STAG_QUARTER, 31'd1, 32'hFFFFFFFF, '0, '0);
      8: set_grid(hcfp_pkg::STAG_NONE, 31'd65536, 32'd16777216, 32'h80000000, 32'h7FFFFFFF);
      9: set_grid(hcfp_pkg::STAG_MOD3, 31'd65536, 32'd16777216, 32'h7FFFFFFF, 32'h80000000);
      default: begin
        m = hcfp_pkg::stagger_t'($urandom_range(0, 3));
        inv_v = ($urandom_range(0, 3) == 0) ? hcfp_pkg::INV_W'($urandom()) : recip_of(s);
        set_grid(m, s, inv_v, small_ofs(), small_ofs());
      end
    endcase
  endtask

  task automatic run_random(int count);
    bit steady;
    steady = 1'b0;
    for (int i = 0; i < count; i++) begin
      // stretches without gaps now and then
      if (i % 32 == 0) steady = ($urandom_range(0, 2) == 0);
      send_item(pick_pos(), pick_pos(), pick_layer(), 1'b0, '0);
      if ($urandom_range(0, 199) == 0) wait_drained();
      else idle(gap_len(steady));
    end
  endtask

  // main sequence
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table under the reset register values
    for (int i = 0; i < N_PROBES; i++) begin
      send_item(PROBES[i].px, PROBES[i].py, PROBES[i].lay, PROBES[i].typed, PROBES[i].want);
      idle(gap_len(1'b0));
    end

    // one register setting per phase, changed only once drained
    for (int k = 0; k < N_PHASES; k++) begin
      wait_drained();
      configure_phase(k);
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (LATENCY + 8) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/hcfp_pkg.sv
design/hex_cell_from_position.sv
dv/tb_hex_cell_from_position.sv
